>>> rtl/per_core_event_ring_drain_top_macros.svh
// Assertion macros for the per-core event ring drain block.
`ifndef PER_CORE_EVENT_RING_DRAIN_TOP_MACROS_SVH
`define PER_CORE_EVENT_RING_DRAIN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PCERD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcerd: assertion failed");
`define PCERD_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pcerd: forbidden condition seen");
`else
`define PCERD_ASSERT(label, clk, rst, prop)
`define PCERD_NEVER(label, clk, rst, expr)
`endif
`endif

>>> rtl/pcerd_pkg.sv
// Types, constants and helpers shared by the per-core event ring drain block.
package pcerd_pkg;

  localparam int CORES      = 4;
  localparam int RING_DEPTH = 16;

  localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SLOTS  = CORES * RING_DEPTH;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int REC_W  = 24;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = CMDQ_AW + 1;

  localparam int OB_DEPTH = 4;
  localparam int OB_AW    = 2;
  localparam int OB_CW    = OB_AW + 1;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  core;
    logic [15:0] task_req;
    logic [7:0]  task_state;
  } item_t;

  typedef struct packed {
    logic [7:0]  rec_core;
    logic [15:0] rec_task;
    logic [7:0]  rec_state;
    logic [7:0]  dropped_count;
    logic        last;
  } result_t;

  typedef struct packed {
    op_t               op;
    logic [CORE_W-1:0] core;
    logic [15:0]       task_id;
    logic [7:0]        state_code;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] slot_addr(input logic [CORE_W-1:0] core,
                                                  input logic [PTR_W-1:0] ptr);
    slot_addr = SLOT_W'(core) * SLOT_W'(RING_DEPTH) + SLOT_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
    if (ptr == PTR_W'(RING_DEPTH - 1)) begin
      ptr_advance = '0;
    end else begin
      ptr_advance = ptr + PTR_W'(1);
    end
  endfunction

endpackage

>>> rtl/pcerd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcerd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pcerd_cmdq.sv
// Short command queue between the front classifier and the back executor.
module pcerd_cmdq (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  pcerd_pkg::cmd_t wr_cmd,
  output logic            full,
  input  logic            rd_en,
  output pcerd_pkg::cmd_t rd_cmd,
  output logic            empty
);
  import pcerd_pkg::*;

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] cnt;
  logic               do_wr;
  logic               do_rd;

  assign full   = (cnt == CMDQ_CW'(CMDQ_DEPTH));
  assign empty  = (cnt == '0);
  assign rd_cmd = q[rd_ptr];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + CMDQ_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + CMDQ_AW'(1);
      end
      cnt <= cnt + CMDQ_CW'(do_wr) - CMDQ_CW'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= wr_cmd;
    end
  end

endmodule

>>> rtl/pcerd_front.sv
// Front end: accepts input words, drops out-of-range stores, builds commands.
module pcerd_front (
  input  logic             push,
  input  pcerd_pkg::item_t item,
  output logic             full,
  input  logic             q_full,
  output logic             q_wr,
  output pcerd_pkg::cmd_t  q_cmd
);
  import pcerd_pkg::*;

  logic is_drain;
  logic keep;

  always_comb begin
    is_drain         = (item.opcode == OP_DRAIN);
    // Stores to a core at or above the configured count vanish here
    keep             = is_drain || (item.core < 8'(CORES));
    full             = q_full;
    q_wr             = push && !q_full && keep;
    q_cmd.op         = is_drain ? OP_DRAIN : OP_STORE;
    q_cmd.core       = item.core[CORE_W-1:0];
    q_cmd.task_id    = item.task_req;
    q_cmd.state_code = item.task_state;
  end

endmodule

>>> rtl/pcerd_back.sv
// Back end: per-core ring bookkeeping, record RAM, drain walk and result queue.
`include "per_core_event_ring_drain_top_macros.svh"
module pcerd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  pcerd_pkg::cmd_t   cmd,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              empty,
  output pcerd_pkg::result_t result
);
  import pcerd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t            state;
  logic [CORE_W-1:0] dcore;
  logic [PTR_W-1:0]  wp   [CORES];
  logic [PTR_W-1:0]  rp   [CORES];
  logic [CNT_W-1:0]  fill [CORES];
  logic [7:0]        drop [CORES];

  logic [CORE_W-1:0] cur_core;
  logic [PTR_W-1:0]  cur_wp;
  logic [PTR_W-1:0]  cur_rp;
  logic [CNT_W-1:0]  cur_fill;
  logic [7:0]        cur_drop;
  logic              ring_full;
  logic              later_empty;
  logic              all_empty;
  logic              credit_ok;
  logic              do_store;
  logic              issue;
  logic [SLOT_W-1:0] waddr;
  logic [SLOT_W-1:0] raddr;
  logic [REC_W-1:0]  rdata;

  // Read stage metadata, aligned with the RAM output
  logic              rd_vld;
  logic [CORE_W-1:0] rd_core;
  logic [7:0]        rd_drop;
  logic              rd_last;

  result_t           ob [OB_DEPTH];
  logic [OB_AW-1:0]  ob_wr;
  logic [OB_AW-1:0]  ob_rd;
  logic [OB_CW-1:0]  ob_cnt;
  logic              ob_pop;

  always_comb begin
    cur_core  = (state == S_DRAIN) ? dcore : cmd.core;
    cur_wp    = wp[cur_core];
    cur_rp    = rp[cur_core];
    cur_fill  = fill[cur_core];
    cur_drop  = drop[cur_core];
    ring_full = (cur_fill == CNT_W'(RING_DEPTH));

    later_empty = 1'b1;
    all_empty   = 1'b1;
    for (int c = 0; c < CORES; c++) begin
      if (fill[c] != '0) begin
        all_empty = 1'b0;
        if (CORE_W'(c) > dcore) begin
          later_empty = 1'b0;
        end
      end
    end

    // Leave room for the read already in flight
    credit_ok = (ob_cnt + OB_CW'(rd_vld)) < OB_CW'(OB_DEPTH);
    cmd_pop   = (state == S_IDLE) && cmd_valid;
    do_store  = cmd_pop && (cmd.op == OP_STORE);
    issue     = (state == S_DRAIN) && (cur_fill != '0) && credit_ok;
    waddr     = slot_addr(cur_core, cur_wp);
    raddr     = slot_addr(cur_core, cur_rp);

    empty  = (ob_cnt == '0);
    result = ob[ob_rd];
    ob_pop = pop && !empty;
  end

  pcerd_ram #(
    .WIDTH(REC_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (do_store && !ring_full),
    .waddr (waddr),
    .wdata ({cmd.task_id, cmd.state_code}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dcore  <= '0;
      rd_vld <= 1'b0;
      ob_wr  <= '0;
      ob_rd  <= '0;
      ob_cnt <= '0;
      for (int c = 0; c < CORES; c++) begin
        wp[c]   <= '0;
        rp[c]   <= '0;
        fill[c] <= '0;
        drop[c] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid && (cmd.op == OP_DRAIN)) begin
            state <= S_DRAIN;
            dcore <= '0;
          end
        end
        S_DRAIN: begin
          // Advance to the next core once this ring runs dry, or return to idle after the last core
          if (cur_fill == '0) begin
            if (dcore == CORE_W'(CORES - 1)) begin
              state <= S_IDLE;
            end else begin
              dcore <= dcore + CORE_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (do_store) begin
        if (ring_full) begin
          drop[cur_core] <= cur_drop + 8'd1;
        end else begin
          wp[cur_core]   <= ptr_advance(cur_wp);
          fill[cur_core] <= cur_fill + CNT_W'(1);
        end
      end
      if (issue) begin
        rp[cur_core]   <= ptr_advance(cur_rp);
        fill[cur_core] <= cur_fill - CNT_W'(1);
      end

      rd_vld <= issue;
      if (rd_vld) begin
        ob_wr <= ob_wr + OB_AW'(1);
      end
      if (ob_pop) begin
        ob_rd <= ob_rd + OB_AW'(1);
      end
      ob_cnt <= ob_cnt + OB_CW'(rd_vld) - OB_CW'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    rd_core <= cur_core;
    rd_drop <= cur_drop;
    rd_last <= (cur_fill == CNT_W'(1)) && later_empty;
    if (rd_vld) begin
      ob[ob_wr].rec_core      <= 8'(rd_core);
      ob[ob_wr].rec_task      <= rdata[23:8];
      ob[ob_wr].rec_state     <= rdata[7:0];
      ob[ob_wr].dropped_count <= rd_drop;
      ob[ob_wr].last          <= rd_last;
    end
  end

  `PCERD_NEVER(a_ob_overflow, clk, rst, rd_vld && (ob_cnt == OB_CW'(OB_DEPTH)))
  `PCERD_ASSERT(a_last_all_empty, clk, rst, (rd_vld && rd_last) |-> all_empty)
  `PCERD_ASSERT(a_drain_done_empty, clk, rst, $fell(state == S_DRAIN) |-> all_empty)
  `PCERD_ASSERT(a_ob_count, clk, rst, (ob_cnt == OB_CW'(OB_DEPTH)) || (OB_AW'(ob_cnt) == OB_AW'(ob_wr - ob_rd)))

endmodule

>>> rtl/per_core_event_ring_drain_top.sv
// Per-core event ring drain: top level joining front end, command queue and back end.
//
// Input channel (push/full): each word is a store (opcode 0) that appends a task
// record to its core's ring, or a drain (opcode 1) that empties every ring.
// Stores to a core at or above the core count are discarded; a store to a full
// ring is discarded and bumps that core's wrapping 8-bit drop counter.
// Result channel (empty/pop): one word per drained record, core 0 first and
// oldest record first, with the core's drop count and a last flag on the
// final record of the drain. A drain of empty rings gives no word.
// A store is written to the record RAM when the back end takes it from the command
// queue; the first record of a drain passes the command queue, the drain walk, the
// RAM read stage and the result queue, and each empty ring walked ahead delays it.
// Throughput: stores retire one per cycle while no drain walks; a drain streams one
// record per cycle (set by the single read port of the record RAM) while the result
// queue has room; no new word is executed until the walk has finished.
// When the receiver stalls, the four-entry result queue fills and the drain
// walk pauses; the two-entry command queue then raises full.
// Reset clears all ring pointers, fill levels and drop counters at once.
module per_core_event_ring_drain_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  pcerd_pkg::item_t   item,
  output logic               empty,
  input  logic               pop,
  output pcerd_pkg::result_t result
);
  import pcerd_pkg::*;

  logic q_full;
  logic q_wr;
  cmd_t q_wr_cmd;
  logic q_rd;
  cmd_t q_rd_cmd;
  logic q_empty;

  pcerd_front u_front (
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_cmd  (q_wr_cmd)
  );

  pcerd_cmdq u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  pcerd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (q_rd_cmd),
    .cmd_pop   (q_rd),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

>>> sim/per_core_event_ring_drain_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the per-core event ring drain block.
module per_core_event_ring_drain_top_tb;
  import pcerd_pkg::*;

  localparam int HOLD_CYCLES = 150;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  item_t   item = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  // Ring contents as the block should hold them
  logic [15:0]      ring_task  [CORES][RING_DEPTH];
  logic [7:0]       ring_state [CORES][RING_DEPTH];
  logic [PTR_W-1:0] ring_wr    [CORES];
  logic [PTR_W-1:0] ring_rd    [CORES];
  logic [CNT_W-1:0] ring_fill  [CORES];
  logic [7:0]       ring_drops [CORES];
  result_t          drained_q[$];

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  event hold_go;

  int mismatches = 0;
  int words_sent = 0;
  int drains_sent = 0;
  int records_seen = 0;
  int full_stalls = 0;

  per_core_event_ring_drain_top DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic item_t mk_word(op_t op, logic [7:0] core, logic [15:0] tid,
                                    logic [7:0] st);
    item_t w;
    w.opcode     = op;
    w.core       = core;
    w.task_req   = tid;
    w.task_state = st;
    return w;
  endfunction

  function automatic item_t rand_store();
    logic [7:0] core;
    if ($urandom_range(0, 99) < 85) begin
      core = 8'($urandom_range(0, CORES - 1));
    end else begin
      core = 8'($urandom_range(CORES, 255));
    end
    return mk_word(OP_STORE, core, 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)));
  endfunction

  function automatic item_t rand_drain();
    return mk_word(OP_DRAIN, 8'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  task automatic ring_model_apply(input item_t w);
    int total;
    int seen;
    int c;
    result_t r;
    if (op_t'(w.opcode) == OP_STORE) begin
      if (w.core < CORES) begin
        c = w.core;
        if (ring_fill[c] == CNT_W'(RING_DEPTH)) begin
          // drop newest, ring untouched
          ring_drops[c] = ring_drops[c] + 8'd1;
        end else begin
          ring_task[c][ring_wr[c]]  = w.task_req;
          ring_state[c][ring_wr[c]] = w.task_state;
          ring_wr[c]   = (ring_wr[c] == PTR_W'(RING_DEPTH - 1)) ? '0 : ring_wr[c] + 1'b1;
          ring_fill[c] = ring_fill[c] + 1'b1;
        end
      end
    end else begin
      total = 0;
      seen  = 0;
      for (c = 0; c < CORES; c++) begin
        total += ring_fill[c];
      end
      for (c = 0; c < CORES; c++) begin
        while (ring_fill[c] != 0) begin
          seen++;
          r.rec_core      = 8'(c);
          r.rec_task      = ring_task[c][ring_rd[c]];
          r.rec_state     = ring_state[c][ring_rd[c]];
          r.dropped_count = ring_drops[c];
          r.last          = (seen == total);
          drained_q.push_back(r);
          ring_rd[c]   = (ring_rd[c] == PTR_W'(RING_DEPTH - 1)) ? '0 : ring_rd[c] + 1'b1;
          ring_fill[c] = ring_fill[c] - 1'b1;
        end
      end
    end
  endtask

  task automatic push_word(input item_t w);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    words_sent++;
    if (op_t'(w.opcode) == OP_DRAIN) begin
      drains_sent++;
    end
    ring_model_apply(w);
  endtask

  task automatic check_record(input result_t got);
    result_t want;
    if (drained_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected record core %0d task %h state %h drops %0d last %0b",
               $time, got.rec_core, got.rec_task, got.rec_state, got.dropped_count,
               got.last);
    end else begin
      want = drained_q.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: record mismatch: expected core %0d task %h state %h drops %0d last %0b",
                 $time, want.rec_core, want.rec_task, want.rec_state, want.dropped_count,
                 want.last);
        $display("%0t:                  got      core %0d task %h state %h drops %0d last %0b",
                 $time, got.rec_core, got.rec_task, got.rec_state, got.dropped_count,
                 got.last);
      end
    end
  endtask

  // Receiver: check each word taken, then pick the next pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        records_seen++;
        check_record(result);
      end
      pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps running
  initial begin : hold_proc
    int left;
    forever begin
      @(hold_go);
      rx_hold <= 1'b1;
      left = HOLD_CYCLES;
      while (left > 0) begin
        @(posedge clk);
        left--;
      end
      rx_hold <= 1'b0;
    end
  end

  task automatic test_store_extremes();
    push_word(mk_word(OP_STORE, 8'd0, 16'h0000, 8'h00));
    push_word(mk_word(OP_STORE, 8'(CORES - 1), 16'hFFFF, 8'hFF));
    push_word(mk_word(OP_STORE, 8'd2, 16'h8001, 8'h80));
    push_word(mk_word(OP_STORE, 8'(CORES), 16'h1234, 8'h56));
    push_word(mk_word(OP_STORE, 8'hFF, 16'hFFFF, 8'hFF));
    push_word(mk_word(OP_DRAIN, 8'd0, 16'h0000, 8'h00));
  endtask

  task automatic test_empty_drain();
    push_word(mk_word(OP_DRAIN, 8'hFF, 16'hFFFF, 8'hFF));
  endtask

  task automatic test_full_ring();
    repeat (RING_DEPTH + 1) begin
      push_word(mk_word(OP_STORE, 8'd1, 16'($urandom), 8'($urandom)));
    end
    push_word(mk_word(OP_STORE, 8'd0, 16'h00FF, 8'h0F));
    push_word(rand_drain());
  endtask

  // Load the rings with stores, hold the receiver and keep offering words
  task automatic test_backpressure();
    repeat (24) begin
      push_word(mk_word(OP_STORE, 8'($urandom_range(0, CORES - 1)), 16'($urandom),
                        8'($urandom)));
    end
    -> hold_go;
    push_word(rand_drain());
    repeat (8) begin
      push_word(rand_store());
    end
    push_word(rand_drain());
  endtask

  // Overfill one core's ring so several words in a row are dropped
  task automatic test_drop_burst();
    repeat (RING_DEPTH + 6) begin
      push_word(mk_word(OP_STORE, 8'd2, 16'($urandom), 8'($urandom)));
    end
    push_word(rand_drain());
  endtask

  task automatic test_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 9) begin
        push_word(rand_drain());
      end else begin
        push_word(rand_store());
      end
    end
    push_word(rand_drain());
  endtask

  initial begin
    for (int c = 0; c < CORES; c++) begin
      ring_wr[c]    = '0;
      ring_rd[c]    = '0;
      ring_fill[c]  = '0;
      ring_drops[c] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 17;
    rx_idle_pct <= 62;
    test_store_extremes();
    test_empty_drain();
    test_full_ring();
    test_random(16);

    tx_idle_pct = 62;
    rx_idle_pct <= 17;
    test_backpressure();
    test_random(10);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    test_drop_burst();
    test_random(18);

    push <= 1'b0;
    while (drained_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d words including %0d drains; checked %0d drained records.",
             words_sent, drains_sent, records_seen);
    $display("Input held off by full for %0d cycles; full-ring drops and empty drains run.",
             full_stalls);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout with %0d records still expected", drained_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
